// ===== src/csf_pkg.sv =====
// package with types, codes and helpers for the charging session controller
`timescale 1ns / 1ps

package csf_pkg;

  localparam int unsigned TargetMin   = 50;
  localparam int unsigned TargetMax   = 100;
  localparam int unsigned TargetReset = 100;

  typedef enum logic [2:0] {
    ST_DISC     = 3'd0,
    ST_PLUG     = 3'd1,
    ST_HSHK     = 3'd2,
    ST_ACTIVE   = 3'd3,
    ST_LIMITED  = 3'd4,
    ST_COMPLETE = 3'd5,
    ST_FAULT    = 3'd6
  } csf_state_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PLUG    = 2'd1,
    EV_HSHK_OK = 2'd2,
    EV_UNPLUG  = 2'd3
  } csf_event_t;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_CHARGING = 2'd1,
    MODE_FAULT    = 2'd2
  } csf_mode_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic [7:0] evse_offer;
    logic [7:0] bms_limit;
    logic [6:0] charge_level;
    logic       fault_flag;
  } csf_in_t;

  typedef struct packed {
    logic [2:0] new_state;
    logic [7:0] drive_current;
    logic       rejected;
    logic [1:0] mode_out;
  } csf_out_t;

  function automatic logic [6:0] clamp_target(logic [6:0] value);
    logic [6:0] result;
    result = value;
    if (value < 7'(TargetMin)) begin
      result = 7'(TargetMin);
    end else if (value > 7'(TargetMax)) begin
      result = 7'(TargetMax);
    end
    return result;
  endfunction

endpackage

// ===== src/csf_cfg.sv =====
// target level register with clamping on write
`timescale 1ns / 1ps

module csf_cfg (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output logic [6:0] target
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= 7'(csf_pkg::TargetReset);
    end else if (cfg_valid && cfg_ready) begin
      target <= csf_pkg::clamp_target(cfg_data);
    end
  end

endmodule

// ===== src/csf_step.sv =====
// transition logic for one charger event
`timescale 1ns / 1ps

module csf_step (
  input  csf_pkg::csf_state_t state,
  input  csf_pkg::csf_in_t    item,
  input  logic [6:0]          target,
  output csf_pkg::csf_state_t state_next,
  output csf_pkg::csf_out_t   result
);

  logic       matched;
  logic [7:0] cur;

  // next state
  always_comb begin
    state_next = state;
    matched    = 1'b0;
    case (state)
      csf_pkg::ST_DISC: begin
        if (item.event_code == csf_pkg::EV_PLUG) begin
          state_next = csf_pkg::ST_PLUG;
          matched    = 1'b1;
        end
      end
      csf_pkg::ST_PLUG: begin
        if (item.event_code == csf_pkg::EV_HSHK_OK) begin
          state_next = csf_pkg::ST_HSHK;
          matched    = 1'b1;
        end
      end
      csf_pkg::ST_HSHK: begin
        if (item.bms_limit != 8'd0) begin
          state_next = csf_pkg::ST_ACTIVE;
          matched    = 1'b1;
        end
      end
      csf_pkg::ST_ACTIVE: begin
        if (item.bms_limit != 8'd0 && item.bms_limit < item.evse_offer) begin
          state_next = csf_pkg::ST_LIMITED;
          matched    = 1'b1;
        end else if (item.charge_level >= target) begin
          state_next = csf_pkg::ST_COMPLETE;
          matched    = 1'b1;
        end
      end
      csf_pkg::ST_LIMITED: begin
        if (item.charge_level >= target) begin
          state_next = csf_pkg::ST_COMPLETE;
          matched    = 1'b1;
        end
      end
      default: begin
        matched = 1'b0;
      end
    endcase
    // common exits from any plugged state
    if (!matched && state != csf_pkg::ST_DISC) begin
      if (item.fault_flag) begin
        state_next = csf_pkg::ST_FAULT;
        matched    = 1'b1;
      end else if (item.event_code == csf_pkg::EV_UNPLUG) begin
        state_next = csf_pkg::ST_DISC;
        matched    = 1'b1;
      end
    end
  end

  // outputs
  always_comb begin
    cur = 8'd0;
    case (state)
      csf_pkg::ST_HSHK: begin
        if (state_next == csf_pkg::ST_ACTIVE) begin
          cur = (item.evse_offer < item.bms_limit) ? item.evse_offer : item.bms_limit;
        end
      end
      csf_pkg::ST_ACTIVE: begin
        if (state_next == csf_pkg::ST_LIMITED) begin
          cur = item.bms_limit;
        end
      end
      default: begin
        cur = 8'd0;
      end
    endcase
    result.new_state     = state_next;
    result.drive_current = cur;
    result.rejected      = !matched;
    case (state_next)
      csf_pkg::ST_DISC:  result.mode_out = csf_pkg::MODE_OFF;
      csf_pkg::ST_FAULT: result.mode_out = csf_pkg::MODE_FAULT;
      default:           result.mode_out = csf_pkg::MODE_CHARGING;
    endcase
  end

endmodule

// ===== src/charge_session_fsm_top.sv =====
// top level of the charging session controller
// out_valid rises as an accepted item moves from input to result register
// one transaction per cycle while out_stall is low; state updates on each advance
// the input register refills in the cycle its item moves to the result register
// reset: state disconnected, target level 100, both pipeline registers empty
`timescale 1ns / 1ps

module charge_session_fsm_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  csf_pkg::csf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output csf_pkg::csf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);

  logic                in_full;
  csf_pkg::csf_in_t    in_reg;
  logic                out_free;
  logic                advance;
  logic [6:0]          target;
  csf_pkg::csf_state_t charge_state;
  csf_pkg::csf_state_t charge_state_next;
  csf_pkg::csf_out_t   result;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;

  csf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .target    (target)
  );

  csf_step u_step (
    .state      (charge_state),
    .item       (in_reg),
    .target     (target),
    .state_next (charge_state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_state <= csf_pkg::ST_DISC;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        charge_state <= charge_state_next;
      end
      if (out_free) begin
        out_valid <= in_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("input stalled with empty input register");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && out_data.new_state == charge_state)
    else $error("result state differs from stored state");

  a_reject_zero_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rejected |-> out_data.drive_current == 8'd0)
    else $error("rejected event commands current");

  a_mode_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.new_state == csf_pkg::ST_DISC) ==
                   (out_data.mode_out == csf_pkg::MODE_OFF)))
    else $error("mode does not match state");

  a_target_in_range: assert property (@(posedge clk) disable iff (rst)
    target >= 7'(csf_pkg::TargetMin) && target <= 7'(csf_pkg::TargetMax))
    else $error("target level out of range");

endmodule
